// ----- design/tcgr_pkg.sv -----
// Shared types and constants of the text console glyph renderer.
// Holds the command and register codes, the word structs and the sequencer states.
// No dependencies.
package tcgr_pkg;

    localparam int CMD_W      = 2;
    localparam int CODE_W     = 8;
    localparam int FONT_AW    = 12;
    localparam int FONT_DW    = 8;
    localparam int PIX_XW     = 10;
    localparam int PIX_YW     = 9;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int GY_W       = 4;
    localparam int GLYPH_W    = 8;
    localparam int GLYPH_H    = 16;
    localparam int FONT_DEPTH = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int COLS_DEFAULT = 80;
    localparam int ROWS_DEFAULT = 30;

    localparam logic [CMD_W-1:0] CMD_PRINT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

    localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CODE_W-1:0]  char_code;
        logic [FONT_AW-1:0] font_addr;
        logic [FONT_DW-1:0] font_bits;
        logic [PIX_XW-1:0]  pixel_x;
        logic [PIX_YW-1:0]  pixel_y;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic             scrolled;
        logic             pixel_lit;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_ADVANCE,
        S_NEWLINE,
        S_COPY,
        S_BLANK,
        S_READ,
        S_DONE
    } t_state;

endpackage

// ----- design/tcgr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/text_console_glyph_renderer_top.sv -----
// Top level of the text console glyph renderer: sequencer, cursor, registers, output word.
// Depends on tcgr_pkg and on tcgr_ram for the font store and the frame store.
//
// The block takes one command word at a time and returns one result word for each. A font
// byte is written into the font store as its load command is taken; an in-frame pixel readback
// passes through a read state before its result. Printing a character writes the 16 glyph rows into
// the frame store one byte per cycle, then advances the cursor. A scroll moves the text area
// up by one text row and then blanks the last text row. The frame store has a single write
// port, taking one 8-pixel byte per cycle. After reset the frame store is cleared by a sweep
// during which no command word is taken; register writes are taken at any time. The frame
// store holds one byte per glyph row of a character cell, bit 7 being the leftmost pixel,
// with a fixed stride of MAX_COLUMNS bytes per pixel row. A finished result word waits in an
// output register, so the next command word can already be taken.
// The configuration port is always ready and should only be written while no command is
// in progress.
module text_console_glyph_renderer_top #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 30
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tcgr_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tcgr_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import tcgr_pkg::*;

    // Frame store geometry: one byte per glyph row of a cell.
    localparam int FRAME_LINES = MAX_ROWS * GLYPH_H;
    localparam int FRAME_PIX_W = MAX_COLUMNS * GLYPH_W;
    localparam int FRAME_DEPTH = MAX_COLUMNS * FRAME_LINES;
    localparam int CELL_SPAN   = GLYPH_H * MAX_COLUMNS;
    localparam int FA_W        = $clog2(FRAME_DEPTH);
    localparam int LY_W        = $clog2(FRAME_LINES + 1);

    localparam logic [FA_W-1:0] LINE_STEP = FA_W'(MAX_COLUMNS);
    localparam logic [FA_W-1:0] CELL_STEP = FA_W'(CELL_SPAN);
    localparam logic [FA_W-1:0] CLR_LAST  = FA_W'(FRAME_DEPTH - 1);

    localparam logic [COL_W-1:0] COLS_RESET =
        COL_W'((COLS_DEFAULT > MAX_COLUMNS) ? MAX_COLUMNS : COLS_DEFAULT);
    localparam logic [ROW_W-1:0] ROWS_RESET =
        ROW_W'((ROWS_DEFAULT > MAX_ROWS) ? MAX_ROWS : ROWS_DEFAULT);

    t_state            r_state, n_state;
    logic [FA_W-1:0]   r_clr, n_clr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_cols, n_cols;
    logic [ROW_W-1:0]  r_rows, n_rows;
    logic [CODE_W-1:0] r_code, n_code;
    logic [GY_W-1:0]   r_gy, n_gy;
    logic [COL_W-1:0]  r_c, n_c;
    logic [LY_W-1:0]   r_y, n_y;
    logic [FA_W-1:0]   r_lbase, n_lbase;
    logic [FA_W-1:0]   r_bbase, n_bbase;
    logic              r_draw_en, n_draw_en;
    logic              r_scrolled, n_scrolled;
    logic              r_lit, n_lit;
    logic [2:0]        r_bit, n_bit;
    logic              r_wr_valid, n_wr_valid;
    logic [FA_W-1:0]   r_wr_addr, n_wr_addr;
    logic              r_wr_glyph, n_wr_glyph;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic                in_accept;
    logic                glyph_we;
    logic [FONT_AW-1:0]  glyph_raddr;
    logic [FONT_DW-1:0]  glyph_rdata;
    logic                frame_we;
    logic [FA_W-1:0]     frame_waddr;
    logic [FONT_DW-1:0]  frame_wdata;
    logic [FA_W-1:0]     frame_raddr;
    logic [FONT_DW-1:0]  frame_rdata;
    logic [FA_W-1:0]     pix_addr;
    logic                pix_in_frame;
    logic [FA_W-1:0]     copy_src;
    logic [LY_W-1:0]     last_line;
    logic [COL_W-1:0]    col_inc;
    logic [ROW_W-1:0]    row_inc;
    logic [COL_W-1:0]    cfg_cols;
    logic [ROW_W-1:0]    cfg_rows;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    // Pixel readback address: row stride is fixed at MAX_COLUMNS bytes.
    assign pix_addr     = FA_W'(i_in_word.pixel_y * MAX_COLUMNS)
                        + FA_W'(i_in_word.pixel_x[PIX_XW-1:3]);
    assign pix_in_frame = (int'(i_in_word.pixel_x) < FRAME_PIX_W)
                       && (int'(i_in_word.pixel_y) < FRAME_LINES);

    // While scrolling, each source byte moves up by one text row (16 pixel rows).
    assign copy_src  = r_lbase + FA_W'(r_c);
    assign last_line = LY_W'({r_rows, 4'b0000}) - LY_W'(1);
    assign col_inc   = r_col + COL_W'(1);
    assign row_inc   = r_row + ROW_W'(1);

    // Register values of 0 act as 1, large ones saturate at the maximum; rows take only the low ROW_W bits.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cols = COL_W'(1);
        end else if (int'(i_cfg_data) > MAX_COLUMNS) begin
            cfg_cols = COL_W'(MAX_COLUMNS);
        end else begin
            cfg_cols = i_cfg_data;
        end
        if (i_cfg_data[ROW_W-1:0] == '0) begin
            cfg_rows = ROW_W'(1);
        end else if (int'(i_cfg_data[ROW_W-1:0]) > MAX_ROWS) begin
            cfg_rows = ROW_W'(MAX_ROWS);
        end else begin
            cfg_rows = i_cfg_data[ROW_W-1:0];
        end
    end

    // The font store is written only by the load command, straight from the input word.
    assign glyph_we    = in_accept && (i_in_word.cmd == CMD_LOAD);
    assign glyph_raddr = {r_code, r_gy};

    // Frame store writes come from the one-deep write stage, or from the reset sweep.
    // The write stage takes its data from whichever store was read in the cycle before.
    assign frame_we    = r_wr_valid || (r_state == S_CLEAR);
    assign frame_waddr = (r_state == S_CLEAR) ? r_clr : r_wr_addr;
    assign frame_wdata = (r_state == S_CLEAR) ? '0 :
                         (r_wr_glyph ? glyph_rdata : frame_rdata);
    assign frame_raddr = (r_state == S_COPY) ? copy_src : pix_addr;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_col       = r_col;
        n_row       = r_row;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_code      = r_code;
        n_gy        = r_gy;
        n_c         = r_c;
        n_y         = r_y;
        n_lbase     = r_lbase;
        n_bbase     = r_bbase;
        n_draw_en   = r_draw_en;
        n_scrolled  = r_scrolled;
        n_lit       = r_lit;
        n_bit       = r_bit;
        n_wr_valid  = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_wr_glyph  = r_wr_glyph;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COLUMNS: n_cols = cfg_cols;
                CFG_ROWS:    n_rows = cfg_rows;
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + FA_W'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_scrolled = 1'b0;
                    n_lit      = 1'b0;
                    n_bit      = i_in_word.pixel_x[2:0];
                    case (i_in_word.cmd)
                        CMD_PRINT: begin
                            if (i_in_word.char_code == CODE_NEWLINE) begin
                                n_state = S_NEWLINE;
                            end else begin
                                n_code    = i_in_word.char_code;
                                n_gy      = '0;
                                n_lbase   = FA_W'(int'(r_row) * CELL_SPAN) + FA_W'(r_col);
                                n_draw_en = (int'(r_row) < MAX_ROWS)
                                         && (int'(r_col) < MAX_COLUMNS);
                                n_state   = S_DRAW;
                            end
                        end
                        CMD_READ: begin
                            n_state = pix_in_frame ? S_READ : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DRAW: begin
                // Glyph row r_gy is read now and written in the next cycle.
                n_wr_valid = r_draw_en;
                n_wr_addr  = r_lbase;
                n_wr_glyph = 1'b1;
                n_lbase    = r_lbase + LINE_STEP;
                n_gy       = r_gy + GY_W'(1);
                if (r_gy == GY_W'(GLYPH_H - 1)) begin
                    n_state = S_ADVANCE;
                end
            end
            S_ADVANCE: begin
                if ((col_inc >= r_cols) || (col_inc == '0)) begin
                    n_state = S_NEWLINE;
                end else begin
                    n_col   = col_inc;
                    n_state = S_DONE;
                end
            end
            S_NEWLINE: begin
                n_col = '0;
                if ((row_inc < r_rows) && (row_inc != '0)) begin
                    n_row   = row_inc;
                    n_state = S_DONE;
                end else begin
                    n_scrolled = 1'b1;
                    n_row      = r_rows - ROW_W'(1);
                    n_c        = '0;
                    n_gy       = '0;
                    n_y        = LY_W'(GLYPH_H);
                    n_lbase    = CELL_STEP;
                    n_bbase    = FA_W'(int'(r_rows - ROW_W'(1)) * CELL_SPAN);
                    n_code     = CODE_SPACE;
                    n_state    = (r_rows == ROW_W'(1)) ? S_BLANK : S_COPY;
                end
            end
            S_COPY: begin
                // Writes always land one text row above the reads, so no row is overwritten before it is read.
                n_wr_valid = 1'b1;
                n_wr_addr  = copy_src - CELL_STEP;
                n_wr_glyph = 1'b0;
                if (r_c == r_cols - COL_W'(1)) begin
                    n_c     = '0;
                    n_lbase = r_lbase + LINE_STEP;
                    n_y     = r_y + LY_W'(1);
                    if (r_y == last_line) begin
                        n_state = S_BLANK;
                    end
                end else begin
                    n_c = r_c + COL_W'(1);
                end
            end
            S_BLANK: begin
                // The space glyph row r_gy is read every cycle and written across the row.
                n_wr_valid = 1'b1;
                n_wr_addr  = r_bbase + FA_W'(r_c);
                n_wr_glyph = 1'b1;
                if (r_c == r_cols - COL_W'(1)) begin
                    n_c     = '0;
                    n_gy    = r_gy + GY_W'(1);
                    n_bbase = r_bbase + LINE_STEP;
                    if (r_gy == GY_W'(GLYPH_H - 1)) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_c = r_c + COL_W'(1);
                end
            end
            S_READ: begin
                // Bit 7 is the leftmost pixel, so pixel offset b sits at bit 7 - b.
                n_lit   = frame_rdata[~r_bit];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out_word.cursor_col = r_col;
                    n_out_word.cursor_row = r_row;
                    n_out_word.scrolled   = r_scrolled;
                    n_out_word.pixel_lit  = r_lit;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_cols      <= COLS_RESET;
            r_rows      <= ROWS_RESET;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_cols      <= n_cols;
            r_rows      <= n_rows;
            r_wr_valid  <= n_wr_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_gy       <= n_gy;
        r_c        <= n_c;
        r_y        <= n_y;
        r_lbase    <= n_lbase;
        r_bbase    <= n_bbase;
        r_draw_en  <= n_draw_en;
        r_scrolled <= n_scrolled;
        r_lit      <= n_lit;
        r_bit      <= n_bit;
        r_wr_addr  <= n_wr_addr;
        r_wr_glyph <= n_wr_glyph;
        r_out_word <= n_out_word;
    end

    tcgr_ram #(
        .WIDTH (FONT_DW),
        .DEPTH (FONT_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (glyph_we),
        .i_waddr (i_in_word.font_addr),
        .i_wdata (i_in_word.font_bits),
        .i_raddr (glyph_raddr),
        .o_rdata (glyph_rdata)
    );

    tcgr_ram #(
        .WIDTH (FONT_DW),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (frame_waddr),
        .i_wdata (frame_wdata),
        .i_raddr (frame_raddr),
        .o_rdata (frame_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // A new command never starts while a frame store write is still in flight.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_wr_valid)
        else $error("command accepted with a frame write pending");

    // The reset sweep owns the frame write port alone.
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_wr_valid)
        else $error("frame write stage active during the clearing sweep");

    // After a scroll the cursor sits at column 0 of the last text row.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_scrolled) |-> ((r_row == r_rows - ROW_W'(1)) && (r_col == '0)))
        else $error("cursor not on the last row after a scroll");

    // A result word is produced only by finishing a command.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word appeared outside the finishing step");
`endif

endmodule
